// ===== hw/rtl/qslerp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types, formats and constants of the fixed-point slerp pipeline.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    localparam int IFB      = 30;   // fraction bits of angles, sines, weights
    localparam int CW       = 34;   // CORDIC datapath width
    localparam int SW       = 31;   // cosine, sine of half angle, factor
    localparam int WW       = 42;   // signed weight width
    localparam int SQRT_LAT = 31;   // one root bit per stage
    localparam int DIV_LAT  = 43;   // prep stage, 41 quotient bits, sign stage

    localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
    localparam logic signed [WW-1:0] WLIM     = WW'(64'd1 << 40);
    localparam logic [SW-1:0]        ONE_I    = SW'(64'd1 << IFB);

    localparam logic [1:0] PATH_SPH   = 2'd0;
    localparam logic [1:0] PATH_START = 2'd1;
    localparam logic [1:0] PATH_LIN   = 2'd2;

    localparam logic       REG_THR   = 1'b0;   // register index decoded from paddr[2]
    localparam logic [14:0] THR_RESET = 15'd16;

    typedef struct packed {
        logic [3:0][15:0] qa;
        logic [3:0][16:0] qb;     // end quaternion, may be negated
        logic [SW-1:0]    t;
        logic [1:0]       path;
        logic [SW-1:0]    c;
        logic [SW-1:0]    s;
    } ctx_t;

    function automatic logic signed [CW-1:0] atan_i30(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0:       r = 34'sd843314857;
            1:       r = 34'sd497837830;
            2:       r = 34'sd263043837;
            3:       r = 34'sd133525159;
            4:       r = 34'sd67021687;
            5:       r = 34'sd33543516;
            6:       r = 34'sd16775851;
            7:       r = 34'sd8388437;
            8:       r = 34'sd4194283;
            9:       r = 34'sd2097149;
            10:      r = 34'sd1048576;
            default: r = (i <= 30) ? CW'(64'd1 << (30 - i)) : '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/quaternion_slerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point quaternion spherical linear interpolation, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_ready) takes a word of start and end
// quaternions plus blend factor; output channel (result_valid/result_ready)
// returns the interpolated quaternion and the path code.
// Throughput: one word per cycle while the receiver does not stall. The pipeline
// runs the 31-stage square root, the angle CORDIC, the two sine CORDIC lanes and
// the 43-stage weight dividers in series.
// The weight lanes and the four component lanes run side by side; the merge
// after the dividers combines them per path (spherical, start, linear).
// When the receiver stalls with a result pending, the whole pipeline holds
// and item_ready drops in the same cycle; bubbles inside the pipeline are
// not squeezed out.
// Reset empties the pipeline and sets the small-sine threshold to 16.
// The threshold sits at APB address 0; the user must write it only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module quaternion_slerp #(
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic signed [15:0] start_comp0,
    input  logic signed [15:0] start_comp1,
    input  logic signed [15:0] start_comp2,
    input  logic signed [15:0] start_comp3,
    input  logic signed [15:0] end_comp0,
    input  logic signed [15:0] end_comp1,
    input  logic signed [15:0] end_comp2,
    input  logic signed [15:0] end_comp3,
    input  logic [14:0]        blend_factor,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [15:0] out_comp0,
    output logic signed [15:0] out_comp1,
    output logic signed [15:0] out_comp2,
    output logic signed [15:0] out_comp3,
    output logic [1:0]         path_taken
);
    localparam int CW    = qslerp_pkg::CW;
    localparam int SW    = qslerp_pkg::SW;
    localparam int WW    = qslerp_pkg::WW;
    localparam int NA    = qslerp_pkg::SQRT_LAT;
    localparam int LB    = 2 * CORDIC_STEPS + 2 + qslerp_pkg::DIV_LAT;
    localparam int LSH_T = qslerp_pkg::IFB - FRAC_BITS;
    localparam int CSH   = 2 * FRAC_BITS - qslerp_pkg::IFB;
    localparam int RSH   = (CSH > 0) ? CSH : 1;
    localparam int LSH_C = (CSH < 0) ? -CSH : 0;
    localparam logic [SW-1:0] ONE_F   = SW'(64'd1 << FRAC_BITS);
    localparam logic [63:0]   DOT_ONE = 64'd1 << (2 * FRAC_BITS);

    function automatic logic signed [CW-1:0] rnd_i30(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [65:0] q;
        mag = v[65] ? 66'(-v) : 66'(v);
        q   = (mag + (66'd1 << 29)) >> qslerp_pkg::IFB;
        return v[65] ? -CW'(q) : CW'(q);
    endfunction

    // ---------------- configuration ----------------
    logic [14:0] thr_reg;
    logic        cfg_wr;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == qslerp_pkg::REG_THR);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= qslerp_pkg::THR_RESET;
        else if (cfg_wr)
            thr_reg <= pwdata[14:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr[2] == qslerp_pkg::REG_THR) ? {17'b0, thr_reg} : '0;

    // ---------------- flow control ----------------
    logic out_valid_reg;
    logic adv;
    assign adv        = !out_valid_reg || result_ready;
    assign item_ready = adv;

    // ---------------- stage 1: products ----------------
    logic signed [15:0] qa_in [4];
    logic signed [15:0] qb_in [4];
    logic [SW-1:0]      t_sat;
    assign qa_in[0] = start_comp0;
    assign qa_in[1] = start_comp1;
    assign qa_in[2] = start_comp2;
    assign qa_in[3] = start_comp3;
    assign qb_in[0] = end_comp0;
    assign qb_in[1] = end_comp1;
    assign qb_in[2] = end_comp2;
    assign qb_in[3] = end_comp3;
    assign t_sat = (SW'(blend_factor) > ONE_F) ? ONE_F : SW'(blend_factor);

    logic signed [31:0] prod_reg [4];
    qslerp_pkg::ctx_t   c1_next;
    qslerp_pkg::ctx_t   c1_reg;
    logic               v1_reg;

    always_comb
    begin
        c1_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            c1_next.qa[i] = qa_in[i];
            c1_next.qb[i] = 17'(qb_in[i]);
        end
        c1_next.t = t_sat;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                prod_reg[i] <= qa_in[i] * qb_in[i];
            c1_reg <= c1_next;
        end
    end

    // ---------------- stage 2: dot, short path, cosine ----------------
    logic signed [34:0] dot;
    logic [34:0]        adot;
    qslerp_pkg::ctx_t   c2_next;
    qslerp_pkg::ctx_t   c2_reg;
    logic               v2_reg;

    assign dot  = 35'(prod_reg[0]) + 35'(prod_reg[1]) + 35'(prod_reg[2]) + 35'(prod_reg[3]);
    assign adot = dot[34] ? 35'(-dot) : 35'(dot);

    always_comb
    begin
        c2_next = c1_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (dot[34])
                c2_next.qb[i] = -c1_reg.qb[i];
        end
        c2_next.path = (64'(adot) >= DOT_ONE) ? qslerp_pkg::PATH_START : qslerp_pkg::PATH_SPH;
        c2_next.c    = (CSH > 0) ? SW'((64'(adot) + (64'd1 << (RSH - 1))) >> RSH)
                                 : SW'(64'(adot) << LSH_C);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            c2_reg <= c2_next;
    end

    // ---------------- stage 3: c squared ----------------
    logic [61:0]      cc_reg;
    qslerp_pkg::ctx_t c3_reg;
    logic             v3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cc_reg <= c2_reg.c * c2_reg.c;
            c3_reg <= c2_reg;
        end
    end

    // ---------------- sine of half angle ----------------
    logic [60:0] rad;
    logic [30:0] s_root;
    assign rad = 61'((62'd1 << 60) - cc_reg);

    qslerp_isqrt u_isqrt (
        .clk  (clk),
        .adv  (adv),
        .rad  (rad),
        .root (s_root)
    );

    qslerp_pkg::ctx_t ctxa_reg [NA];
    logic             va_reg   [NA];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctxa_reg[0] <= c3_reg;
            for (int k = 1; k < NA; k++)
                ctxa_reg[k] <= ctxa_reg[k-1];
        end
    end

    qslerp_pkg::ctx_t c4;
    logic [SW-1:0]    thr;
    assign thr = SW'(thr_reg) << LSH_T;
    always_comb
    begin
        c4   = ctxa_reg[NA-1];
        c4.s = s_root;
        if (c4.path != qslerp_pkg::PATH_START && (s_root == '0 || s_root < thr))
            c4.path = qslerp_pkg::PATH_LIN;
    end

    // ---------------- angle ----------------
    logic signed [CW-1:0] th;
    qslerp_vec #(.STEPS(CORDIC_STEPS)) u_vec (
        .clk   (clk),
        .adv   (adv),
        .x_in  (CW'(c4.c)),
        .y_in  (CW'(s_root)),
        .angle (th)
    );

    qslerp_pkg::ctx_t ctxb_reg [LB];
    logic             vb_reg   [LB];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctxb_reg[0] <= c4;
            for (int k = 1; k < LB; k++)
                ctxb_reg[k] <= ctxb_reg[k-1];
        end
    end

    logic [SW-1:0]        t30;
    logic signed [65:0]   pa_reg;
    logic signed [65:0]   pb_reg;
    logic signed [CW-1:0] ang_a_reg;
    logic signed [CW-1:0] ang_b_reg;
    assign t30 = ctxb_reg[CORDIC_STEPS-1].t << LSH_T;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg    <= $signed({1'b0, qslerp_pkg::ONE_I - t30}) * th;
            pb_reg    <= $signed({1'b0, t30}) * th;
            ang_a_reg <= rnd_i30(pa_reg);
            ang_b_reg <= rnd_i30(pb_reg);
        end
    end

    // ---------------- sine and weight lanes ----------------
    logic signed [CW-1:0] sin_a;
    logic signed [CW-1:0] sin_b;
    logic signed [WW-1:0] wa_div;
    logic signed [WW-1:0] wb_div;
    logic [SW-1:0]        s_div;
    assign s_div = ctxb_reg[2 * CORDIC_STEPS + 1].s;

    qslerp_rot #(.STEPS(CORDIC_STEPS)) u_rot_a (
        .clk (clk), .adv (adv), .angle (ang_a_reg), .sine (sin_a)
    );
    qslerp_rot #(.STEPS(CORDIC_STEPS)) u_rot_b (
        .clk (clk), .adv (adv), .angle (ang_b_reg), .sine (sin_b)
    );
    qslerp_div u_div_a (
        .clk (clk), .adv (adv), .sine (sin_a), .s (s_div), .weight (wa_div)
    );
    qslerp_div u_div_b (
        .clk (clk), .adv (adv), .sine (sin_b), .s (s_div), .weight (wb_div)
    );

    // ---------------- merge: weights per path, component lanes ----------------
    qslerp_pkg::ctx_t     ce;
    logic signed [WW-1:0] wa;
    logic signed [WW-1:0] wb;
    assign ce = ctxb_reg[LB-1];

    always_comb
    begin
        case (ce.path)
            qslerp_pkg::PATH_START:
            begin
                wa = WW'(qslerp_pkg::ONE_I);
                wb = '0;
            end
            qslerp_pkg::PATH_LIN:
            begin
                wa = WW'(ONE_F - ce.t) << LSH_T;
                wb = WW'(ce.t) << LSH_T;
            end
            default:
            begin
                wa = wa_div;
                wb = wb_div;
            end
        endcase
    end

    logic signed [57:0] ma_reg [4];
    logic signed [58:0] mb_reg [4];
    logic [1:0]         path_w_reg;
    logic               vw_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ma_reg[i] <= $signed(ce.qa[i]) * wa;
                mb_reg[i] <= $signed(ce.qb[i]) * wb;
            end
            path_w_reg <= ce.path;
        end
    end

    logic signed [15:0] res [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [60:0] sum;
            logic [60:0]        mag;
            logic [60:0]        q;
            logic signed [60:0] sr;
            sum = 61'(ma_reg[i]) + 61'(mb_reg[i]);
            mag = sum[60] ? 61'(-sum) : 61'(sum);
            q   = (mag + (61'd1 << 29)) >> qslerp_pkg::IFB;
            sr  = sum[60] ? -$signed(q) : $signed(q);
            if (sr > 61'sd32767)
                res[i] = 16'sd32767;
            else if (sr < -61'sd32768)
                res[i] = -16'sd32768;
            else
                res[i] = 16'(sr);
        end
    end

    logic signed [15:0] out_reg [4];
    logic [1:0]         path_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                out_reg[i] <= res[i];
            path_reg <= path_w_reg;
        end
    end

    // ---------------- valid tracking ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            vw_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NA; k++)
                va_reg[k] <= 1'b0;
            for (int k = 0; k < LB; k++)
                vb_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= item_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            va_reg[0] <= v3_reg;
            for (int k = 1; k < NA; k++)
                va_reg[k] <= va_reg[k-1];
            vb_reg[0] <= va_reg[NA-1];
            for (int k = 1; k < LB; k++)
                vb_reg[k] <= vb_reg[k-1];
            vw_reg        <= vb_reg[LB-1];
            out_valid_reg <= vw_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_comp0    = out_reg[0];
    assign out_comp1    = out_reg[1];
    assign out_comp2    = out_reg[2];
    assign out_comp3    = out_reg[3];
    assign path_taken   = path_reg;

    // ---------------- assertions ----------------
    a_path_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> path_taken != 2'd3)
        else $error("undefined path code on output");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !item_ready)
        else $error("pipeline advanced while output stalled");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> thr_reg == $past(pwdata[14:0]))
        else $error("threshold register not updated");

    a_weight_lim: assert property (@(posedge clk) disable iff (!rst_n)
        vb_reg[LB-1] |-> (wa_div <= qslerp_pkg::WLIM) && (wa_div >= -qslerp_pkg::WLIM))
        else $error("weight outside clamp range");

endmodule

// ===== hw/rtl/qslerp_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_isqrt
// Pipelined integer square root of a 61-bit radicand, one root bit a stage.
// ----------------------------------------------------------------------------
module qslerp_isqrt (
    input  logic        clk,
    input  logic        adv,
    input  logic [60:0] rad,
    output logic [30:0] root
);
    localparam int N = qslerp_pkg::SQRT_LAT;

    logic [61:0] v_reg [N];
    logic [61:0] r_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam logic [61:0] BK = 62'd1 << (60 - 2 * k);
        logic [61:0] vi;
        logic [61:0] ri;
        logic [61:0] tr;
        logic [61:0] v_next;
        logic [61:0] r_next;
        if (k == 0)
        begin : g_first
            assign vi = {1'b0, rad};
            assign ri = '0;
        end
        else
        begin : g_rest
            assign vi = v_reg[k-1];
            assign ri = r_reg[k-1];
        end
        assign tr     = ri + BK;
        assign v_next = (vi >= tr) ? vi - tr : vi;
        assign r_next = (vi >= tr) ? (ri >> 1) + BK : ri >> 1;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[k] <= v_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[N-1][30:0];

endmodule

// ===== hw/rtl/qslerp_vec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_vec
// Pipelined vectoring CORDIC: angle of (x, y) in I30, one iteration a stage.
// ----------------------------------------------------------------------------
module qslerp_vec #(
    parameter int STEPS = 16
) (
    input  logic                                  clk,
    input  logic                                  adv,
    input  logic signed [qslerp_pkg::CW-1:0]      x_in,
    input  logic signed [qslerp_pkg::CW-1:0]      y_in,
    output logic signed [qslerp_pkg::CW-1:0]      angle
);
    localparam int CW = qslerp_pkg::CW;

    logic signed [CW-1:0] x_reg [STEPS];
    logic signed [CW-1:0] y_reg [STEPS];
    logic signed [CW-1:0] z_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_iter
        localparam logic signed [CW-1:0] AT = qslerp_pkg::atan_i30(k);
        logic signed [CW-1:0] xi;
        logic signed [CW-1:0] yi;
        logic signed [CW-1:0] zi;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        if (k == 0)
        begin : g_first
            assign xi = x_in;
            assign yi = y_in;
            assign zi = '0;
        end
        else
        begin : g_rest
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign zi = z_reg[k-1];
        end
        assign xs = xi >>> k;
        assign ys = yi >>> k;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (yi >= 0)
                begin
                    x_reg[k] <= xi + ys;
                    y_reg[k] <= yi - xs;
                    z_reg[k] <= zi + AT;
                end
                else
                begin
                    x_reg[k] <= xi - ys;
                    y_reg[k] <= yi + xs;
                    z_reg[k] <= zi - AT;
                end
            end
        end
    end

    assign angle = z_reg[STEPS-1];

endmodule

// ===== hw/rtl/qslerp_rot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_rot
// Pipelined rotation CORDIC lane: sine of an I30 angle, gain pre-compensated.
// ----------------------------------------------------------------------------
module qslerp_rot #(
    parameter int STEPS = 16
) (
    input  logic                                  clk,
    input  logic                                  adv,
    input  logic signed [qslerp_pkg::CW-1:0]      angle,
    output logic signed [qslerp_pkg::CW-1:0]      sine
);
    localparam int CW = qslerp_pkg::CW;

    logic signed [CW-1:0] x_reg [STEPS];
    logic signed [CW-1:0] y_reg [STEPS];
    logic signed [CW-1:0] z_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_iter
        localparam logic signed [CW-1:0] AT = qslerp_pkg::atan_i30(k);
        logic signed [CW-1:0] xi;
        logic signed [CW-1:0] yi;
        logic signed [CW-1:0] zi;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        if (k == 0)
        begin : g_first
            assign xi = qslerp_pkg::INV_GAIN;
            assign yi = '0;
            assign zi = angle;
        end
        else
        begin : g_rest
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign zi = z_reg[k-1];
        end
        assign xs = xi >>> k;
        assign ys = yi >>> k;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (zi >= 0)
                begin
                    x_reg[k] <= xi - ys;
                    y_reg[k] <= yi + xs;
                    z_reg[k] <= zi - AT;
                end
                else
                begin
                    x_reg[k] <= xi + ys;
                    y_reg[k] <= yi - xs;
                    z_reg[k] <= zi + AT;
                end
            end
        end
    end

    assign sine = y_reg[STEPS-1];

endmodule

// ===== hw/rtl/qslerp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_div
// Weight lane: round(|sin| * 2^30 / s), clamped at 2^40, sign of sin.
// Restoring division, one quotient bit a stage.
// ----------------------------------------------------------------------------
module qslerp_div (
    input  logic                                  clk,
    input  logic                                  adv,
    input  logic signed [qslerp_pkg::CW-1:0]      sine,
    input  logic [qslerp_pkg::SW-1:0]             s,
    output logic signed [qslerp_pkg::WW-1:0]      weight
);
    localparam int CW = qslerp_pkg::CW;
    localparam int SW = qslerp_pkg::SW;
    localparam int WW = qslerp_pkg::WW;
    localparam int QB = 41;
    localparam int DS = QB + 1;

    logic [63:0]   n_reg   [DS];
    logic [31:0]   rem_reg [DS];
    logic [QB-1:0] q_reg   [DS];
    logic [SW-1:0] s_reg   [DS];
    logic          ovf_reg [DS];
    logic          neg_reg [DS];
    logic signed [WW-1:0] weight_reg;

    // prep: numerator with s/2 folded in; high part at or above s means clamp
    logic [CW-1:0] mag;
    logic [63:0]   num;
    assign mag = sine[CW-1] ? CW'(-sine) : CW'(sine);
    assign num = (64'(mag) << qslerp_pkg::IFB) + 64'(s >> 1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0]   <= num;
            rem_reg[0] <= 32'(num >> QB);
            q_reg[0]   <= '0;
            s_reg[0]   <= s;
            ovf_reg[0] <= (num >> QB) >= 64'(s);
            neg_reg[0] <= sine[CW-1];
        end
    end

    for (genvar k = 1; k < DS; k++)
    begin : g_bit
        localparam int J = QB - k;
        logic [32:0] rem2;
        logic        ge;
        assign rem2 = {rem_reg[k-1], n_reg[k-1][J]};
        assign ge   = rem2 >= 33'(s_reg[k-1]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                n_reg[k]   <= n_reg[k-1];
                rem_reg[k] <= ge ? 32'(rem2 - 33'(s_reg[k-1])) : rem2[31:0];
                q_reg[k]   <= q_reg[k-1] | (QB'(ge) << J);
                s_reg[k]   <= s_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    logic signed [WW-1:0] qs;
    assign qs = (ovf_reg[DS-1] || WW'(q_reg[DS-1]) > qslerp_pkg::WLIM) ?
                qslerp_pkg::WLIM : WW'(q_reg[DS-1]);

    always_ff @(posedge clk)
    begin
        if (adv)
            weight_reg <= neg_reg[DS-1] ? -qs : qs;
    end

    assign weight = weight_reg;

endmodule
